// ===== hdl/qat_pkg.sv =====
// Shared types and constants for the quoted argument tokenizer.
// No dependencies; imported by the result channel interface and the top level.
package qat_pkg;

  // Tokenizer phase
  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_PLAIN,
    PH_QUOTED,
    PH_QESC,
    PH_AFTER_FULL,
    PH_IGNORE
  } phase_t;

  // Byte codes the tokenizer reacts to
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Fixed widths of the result fields
  localparam int ARG_W   = 4;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 5;

endpackage

// ===== hdl/qat_if.sv =====
// Valid/ready channel interfaces for the quoted argument tokenizer.
// Depends on qat_pkg for the result field widths.
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface qat_out_if import qat_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               write_valid;
  logic [ARG_W-1:0]   write_arg;
  logic [POS_W-1:0]   write_pos;
  logic [7:0]         write_char;
  logic               close_valid;
  logic [ARG_W-1:0]   close_arg;
  logic [POS_W-1:0]   close_len;
  logic               line_done;
  logic [COUNT_W-1:0] arg_count;

  modport source (output valid, output write_valid, output write_arg, output write_pos,
                  output write_char, output close_valid, output close_arg,
                  output close_len, output line_done, output arg_count, input ready);
  modport sink   (input valid, input write_valid, input write_arg, input write_pos,
                  input write_char, input close_valid, input close_arg,
                  input close_len, input line_done, input arg_count, output ready);
endinterface

// ===== hdl/quoted_argument_tokenizer.sv =====
// Quoted argument tokenizer top level: input byte register, phase logic, result register.
// Depends on qat_pkg and the channel interfaces in qat_if.sv.
//
// Splits a command line, one byte per word on cmd, into at most MAX_ARGS arguments of at
// most ARG_BYTES-1 bytes. Spaces separate plain tokens; a double quote opens a quoted token
// closed by the next quote, with backslash escapes inside (backslash-n gives newline). A
// zero byte ends the line, closes any open token and reports the argument count. A byte
// that stores, closes or ends the line yields one word on res; other bytes yield none. The
// block takes one byte per cycle while res does not stall: each byte is held in the input
// register, the phase and counters update as it advances, and the result register presents
// the word the cycle after. res valid rises once the byte has passed through the input
// register and the result register; both registers advance together, so a stall on res
// holds the input side only while the result register is full.
module quoted_argument_tokenizer import qat_pkg::*; #(
  parameter int MAX_ARGS  = 16,
  parameter int ARG_BYTES = 64
) (
  input  logic     clk,
  input  logic     rst,
  qat_in_if.sink   cmd,
  qat_out_if.source res
);

  localparam int AW = $clog2(MAX_ARGS + 1);
  localparam int LW = $clog2(ARG_BYTES);

  // Input register
  logic       in_valid;
  logic [7:0] in_ch;

  // Tokenizer state
  phase_t        phase, phase_next;
  logic [AW-1:0] args_found, args_found_next;
  logic [LW-1:0] token_len, token_len_next;

  // Result register
  logic               out_valid;
  logic               write_valid, write_valid_next;
  logic [ARG_W-1:0]   write_arg, write_arg_next;
  logic [POS_W-1:0]   write_pos, write_pos_next;
  logic [7:0]         write_char, write_char_next;
  logic               close_valid, close_valid_next;
  logic [ARG_W-1:0]   close_arg, close_arg_next;
  logic [POS_W-1:0]   close_len, close_len_next;
  logic               line_done, line_done_next;
  logic [COUNT_W-1:0] arg_count, arg_count_next;

  logic advance;

  // Move the held byte on whenever the result register is free or being drained
  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  // Phase register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_BETWEEN;
      args_found <= '0;
      token_len  <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      args_found <= args_found_next;
      token_len  <= token_len_next;
    end
  end

  // Next phase and result word for the held byte
  always_comb begin
    logic          store_en;
    logic [7:0]    store_char;
    logic [LW-1:0] store_base;
    logic [LW-1:0] len_inc;
    phase_t        base_phase;
    phase_t        full_phase;
    logic          close_en;
    logic [LW-1:0] close_src;
    phase_t        close_phase;
    logic [AW-1:0] args_inc;

    store_en    = 1'b0;
    store_char  = in_ch;
    store_base  = token_len;
    base_phase  = phase;
    full_phase  = PH_BETWEEN;
    close_en    = 1'b0;
    close_src   = token_len;
    close_phase = PH_BETWEEN;
    len_inc     = '0;
    args_inc    = args_found + AW'(1);

    phase_next       = phase;
    args_found_next  = args_found;
    token_len_next   = token_len;
    write_valid_next = 1'b0;
    write_arg_next   = '0;
    write_pos_next   = '0;
    write_char_next  = '0;
    close_valid_next = 1'b0;
    close_arg_next   = '0;
    close_len_next   = '0;
    line_done_next   = 1'b0;
    arg_count_next   = '0;

    // Decode the byte against the phase
    if (in_ch == CH_NUL) begin
      close_en = (phase == PH_PLAIN) || (phase == PH_QUOTED) || (phase == PH_QESC);
    end else begin
      unique case (phase)
        PH_IGNORE: begin
        end
        PH_QESC: begin
          store_en   = 1'b1;
          store_char = (in_ch == CH_N) ? CH_NEWLINE : in_ch;
          base_phase = PH_QUOTED;
          full_phase = PH_AFTER_FULL;
        end
        PH_QUOTED: begin
          if (in_ch == CH_QUOTE) begin
            close_en = 1'b1;
          end else if (in_ch == CH_BSLASH) begin
            phase_next = PH_QESC;
          end else begin
            store_en   = 1'b1;
            full_phase = PH_AFTER_FULL;
          end
        end
        PH_PLAIN: begin
          if (in_ch == CH_SPACE) begin
            close_en = 1'b1;
          end else begin
            store_en = 1'b1;
          end
        end
        PH_BETWEEN, PH_AFTER_FULL: begin
          if (in_ch == CH_QUOTE && phase == PH_AFTER_FULL) begin
            phase_next = PH_BETWEEN;
          end else if (in_ch == CH_SPACE) begin
            phase_next = PH_BETWEEN;
          end else if (in_ch == CH_QUOTE) begin
            phase_next     = PH_QUOTED;
            token_len_next = '0;
          end else begin
            store_en   = 1'b1;
            store_base = '0;
            base_phase = PH_PLAIN;
          end
        end
        default: begin
        end
      endcase
    end

    // Store a byte; close the token when it reaches the limit
    if (store_en) begin
      len_inc          = store_base + LW'(1);
      write_valid_next = 1'b1;
      write_arg_next   = ARG_W'(args_found);
      write_pos_next   = POS_W'(store_base);
      write_char_next  = store_char;
      phase_next       = base_phase;
      token_len_next   = len_inc;
      if (len_inc >= LW'(ARG_BYTES - 1)) begin
        close_en    = 1'b1;
        close_src   = len_inc;
        close_phase = full_phase;
      end
    end

    // Close the current argument
    if (close_en) begin
      close_valid_next = 1'b1;
      close_arg_next   = ARG_W'(args_found);
      close_len_next   = POS_W'(close_src);
      args_found_next  = args_inc;
      token_len_next   = '0;
      phase_next       = (args_inc >= AW'(MAX_ARGS)) ? PH_IGNORE : close_phase;
    end

    // End of line: report the count and start a new line
    if (in_ch == CH_NUL) begin
      line_done_next  = 1'b1;
      arg_count_next  = COUNT_W'(args_found_next);
      phase_next      = PH_BETWEEN;
      args_found_next = '0;
      token_len_next  = '0;
    end
  end

  // Input register: hold the byte until it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_ch <= cmd.ch;
    end
  end

  // Result register valid: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= write_valid_next || close_valid_next || line_done_next;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      write_valid <= write_valid_next;
      write_arg   <= write_arg_next;
      write_pos   <= write_pos_next;
      write_char  <= write_char_next;
      close_valid <= close_valid_next;
      close_arg   <= close_arg_next;
      close_len   <= close_len_next;
      line_done   <= line_done_next;
      arg_count   <= arg_count_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.write_valid = write_valid;
  assign res.write_arg   = write_arg;
  assign res.write_pos   = write_pos;
  assign res.write_char  = write_char;
  assign res.close_valid = close_valid;
  assign res.close_arg   = close_arg;
  assign res.close_len   = close_len;
  assign res.line_done   = line_done;
  assign res.arg_count   = arg_count;

endmodule
